[design/fad_pkg.sv]
// Shared constants and types for the fast atan2 (degrees) pipeline.
// Used by every module and by the channel interfaces; depends on nothing.
package fad_pkg;

	// Default input width and default number of fraction bits in the angle.
	localparam int IN_BITS_DEF    = 16;
	localparam int ANGLE_FRAC_DEF = 8;

	// Width of the angle field on the result channel.
	localparam int OUT_W = 17;

	// Ratio min/max is unsigned Q0.16; the raw quotient needs one more bit.
	localparam int RATIO_W = 16;
	localparam int QUOT_W  = RATIO_W + 1;

	// Polynomial coefficients: degrees scaled by 2^20, signed.
	localparam int COEF_W    = 28;
	localparam int COEF_FRAC = 20;
	localparam int RAW_ANG_W = COEF_W - 1;

	localparam logic signed [COEF_W-1:0] P1 = 28'sd60066233;
	localparam logic signed [COEF_W-1:0] P3 = -28'sd19574236;
	localparam logic signed [COEF_W-1:0] P5 = 28'sd9347007;
	localparam logic signed [COEF_W-1:0] P7 = -28'sd2663094;

	// Octant and sign information that travels with each item.
	typedef struct packed {
		logic zero;
		logic swap;
		logic neg_x;
		logic neg_y;
	} side_t;

endpackage

[design/fad_in_if.sv]
// Input channel of the atan2 pipeline: one gradient pair per transfer.
// Depends on fad_pkg for the default width.
interface fad_in_if #(parameter int W = fad_pkg::IN_BITS_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] grad_y;
	logic signed [W-1:0] grad_x;

	modport source(output valid, output grad_y, output grad_x, input ready);
	modport sink(input valid, input grad_y, input grad_x, output ready);
endinterface

[design/fad_out_if.sv]
// Result channel of the atan2 pipeline: one angle per transfer.
// Depends on fad_pkg for the field width.
interface fad_out_if;
	logic                        valid;
	logic                        ready;
	logic [fad_pkg::OUT_W-1:0]   angle_deg;

	modport source(output valid, output angle_deg, input ready);
	modport sink(input valid, input angle_deg, output ready);
endinterface

[design/fad_front.sv]
// Front end: magnitudes and signs of the gradient pair, then octant selection.
// Two pipeline stages; depends on fad_pkg.
module fad_front #(
	parameter int IN_BITS = fad_pkg::IN_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [IN_BITS-1:0] grad_y,
	input  logic signed [IN_BITS-1:0] grad_x,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IN_BITS-1:0]        lo,
	output logic [IN_BITS-1:0]        hi,
	output fad_pkg::side_t            side
);

	logic                v_s1, v_s2;
	logic                en_s1, en_s2;
	logic [IN_BITS-1:0]  mag_y_s1, mag_x_s1;
	logic                neg_y_s1, neg_x_s1;
	logic [IN_BITS-1:0]  lo_s2, hi_s2;
	fad_pkg::side_t      side_s2;

	logic [IN_BITS-1:0]  uy, ux, mag_y, mag_x;
	logic                x_ge_y;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Two's complement magnitude; the most negative code maps to 2^(IN_BITS-1).
	assign uy    = $unsigned(grad_y);
	assign ux    = $unsigned(grad_x);
	assign mag_y = uy[IN_BITS-1] ? (~uy + 1'b1) : uy;
	assign mag_x = ux[IN_BITS-1] ? (~ux + 1'b1) : ux;

	assign x_ge_y = mag_x_s1 >= mag_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			mag_y_s1 <= mag_y;
			mag_x_s1 <= mag_x;
			neg_y_s1 <= uy[IN_BITS-1];
			neg_x_s1 <= ux[IN_BITS-1];
		end
		if (en_s2 && v_s1) begin
			lo_s2         <= x_ge_y ? mag_y_s1 : mag_x_s1;
			hi_s2         <= x_ge_y ? mag_x_s1 : mag_y_s1;
			side_s2.zero  <= (mag_x_s1 == '0) && (mag_y_s1 == '0);
			side_s2.swap  <= !x_ge_y;
			side_s2.neg_x <= neg_x_s1;
			side_s2.neg_y <= neg_y_s1;
		end
	end

	assign out_valid = v_s2;
	assign lo        = lo_s2;
	assign hi        = hi_s2;
	assign side      = side_s2;

endmodule

[design/fad_div.sv]
// Pipelined restoring divider: ratio = round(lo * 2^16 / hi), saturated.
// One quotient bit per stage after the numerator stage; depends on fad_pkg.
module fad_div #(
	parameter int IN_BITS = fad_pkg::IN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [IN_BITS-1:0]            lo,
	input  logic [IN_BITS-1:0]            hi,
	input  fad_pkg::side_t                side_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fad_pkg::RATIO_W-1:0]   ratio,
	output fad_pkg::side_t                side_out
);

	localparam int QW   = fad_pkg::QUOT_W;
	localparam int NW   = IN_BITS + QW;
	localparam int NSTG = QW + 1;

	// Each accumulator holds the partial remainder above the numerator bits
	// still to be consumed, with quotient bits shifting in at the bottom.
	logic [NSTG-1:0]    v_s;
	logic [NSTG-1:0]    en_s;
	logic [NW-1:0]      acc_s  [NSTG];
	logic [IN_BITS-1:0] hi_s   [NSTG];
	fad_pkg::side_t     side_s [NSTG];
	logic [NW-1:0]      acc_nx [1:NSTG-1];
	logic [QW-1:0]      quot;

	for (genvar k = 0; k < NSTG; k++) begin : g_ctl
		if (k == NSTG - 1) begin : g_last
			assign en_s[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign en_s[k] = !v_s[k] || en_s[k+1];
		end
	end

	for (genvar k = 1; k < NSTG; k++) begin : g_step
		logic [IN_BITS:0] trial;
		logic [IN_BITS:0] diff;
		logic             fits;

		always_comb begin
			trial = {acc_s[k-1][NW-1:QW], acc_s[k-1][QW-1]};
			diff  = trial - {1'b0, hi_s[k-1]};
			fits  = trial >= {1'b0, hi_s[k-1]};
			if (fits) begin
				acc_nx[k] = {diff[IN_BITS-1:0], acc_s[k-1][QW-2:0], 1'b1};
			end else begin
				acc_nx[k] = {trial[IN_BITS-1:0], acc_s[k-1][QW-2:0], 1'b0};
			end
		end
	end

	assign in_ready = en_s[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en_s[0]) begin
				v_s[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en_s[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		// Numerator lo * 2^16 + floor(hi / 2) gives round-half-up division.
		if (en_s[0] && in_valid) begin
			acc_s[0]  <= NW'({lo, {fad_pkg::RATIO_W{1'b0}}}) + NW'(hi >> 1);
			hi_s[0]   <= hi;
			side_s[0] <= side_in;
		end
		for (int k = 1; k < NSTG; k++) begin
			if (en_s[k] && v_s[k-1]) begin
				acc_s[k]  <= acc_nx[k];
				hi_s[k]   <= hi_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign quot      = acc_s[NSTG-1][QW-1:0];
	assign out_valid = v_s[NSTG-1];
	assign side_out  = side_s[NSTG-1];

	always_comb begin
		if (side_s[NSTG-1].zero) begin
			ratio = '0;
		end else if (quot[QW-1]) begin
			ratio = '1;
		end else begin
			ratio = quot[fad_pkg::RATIO_W-1:0];
		end
	end

endmodule

[design/fad_poly.sv]
// Odd degree-7 polynomial in the ratio, Horner form, at most one multiply per stage.
// Result is the octant angle in degrees scaled by 2^20; depends on fad_pkg.
module fad_poly (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fad_pkg::RATIO_W-1:0]     ratio,
	input  fad_pkg::side_t                  side_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fad_pkg::RAW_ANG_W-1:0]   raw_ang,
	output fad_pkg::side_t                  side_out
);

	localparam int NSTG   = 10;
	localparam int RW     = fad_pkg::RATIO_W;
	localparam int CW     = fad_pkg::COEF_W;
	localparam int PROD_W = CW + RW + 1;
	localparam int RND_W  = PROD_W - RW;
	localparam int AW     = fad_pkg::RAW_ANG_W;

	// floor((p + 2^15) / 2^16) on a signed product.
	function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = p + PROD_W'(32768);
		return s[PROD_W-1:RW];
	endfunction

	function automatic logic signed [CW-1:0] horner(input logic signed [CW-1:0] coef,
			input logic signed [PROD_W-1:0] p);
		logic signed [RND_W-1:0] s;
		s = rnd16(p) + RND_W'(coef);
		return s[CW-1:0];
	endfunction

	logic [1:NSTG] v_s;
	logic [1:NSTG] en_s;

	logic [2*RW-1:0]          sq_s1;
	logic [RW-1:0]            c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8;
	logic [RW-1:0]            c2_s2, c2_s3, c2_s4, c2_s5, c2_s6;
	logic signed [PROD_W-1:0] prod_s3, prod_s5, prod_s7, prod_s9;
	logic signed [CW-1:0]     t_s4, t_s6, t_s8;
	logic [AW-1:0]            a_s10;
	fad_pkg::side_t           side_s [1:NSTG];

	logic [2*RW-1:0]          sq_rnd;
	logic signed [RND_W-1:0]  a_rnd;

	for (genvar k = 1; k <= NSTG; k++) begin : g_ctl
		if (k == NSTG) begin : g_last
			assign en_s[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign en_s[k] = !v_s[k] || en_s[k+1];
		end
	end

	assign in_ready = en_s[1];
	assign sq_rnd   = sq_s1 + (2*RW)'(32768);
	assign a_rnd    = rnd16(prod_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en_s[1]) begin
				v_s[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en_s[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s[1] && in_valid) begin
			sq_s1     <= ratio * ratio;
			c_s1      <= ratio;
			side_s[1] <= side_in;
		end
		for (int k = 2; k <= NSTG; k++) begin
			if (en_s[k] && v_s[k-1]) begin
				side_s[k] <= side_s[k-1];
			end
		end
		if (en_s[2] && v_s[1]) begin
			c2_s2 <= sq_rnd[2*RW-1:RW];
			c_s2  <= c_s1;
		end
		if (en_s[3] && v_s[2]) begin
			prod_s3 <= fad_pkg::P7 * $signed({1'b0, c2_s2});
			c2_s3   <= c2_s2;
			c_s3    <= c_s2;
		end
		if (en_s[4] && v_s[3]) begin
			t_s4  <= horner(fad_pkg::P5, prod_s3);
			c2_s4 <= c2_s3;
			c_s4  <= c_s3;
		end
		if (en_s[5] && v_s[4]) begin
			prod_s5 <= t_s4 * $signed({1'b0, c2_s4});
			c2_s5   <= c2_s4;
			c_s5    <= c_s4;
		end
		if (en_s[6] && v_s[5]) begin
			t_s6  <= horner(fad_pkg::P3, prod_s5);
			c2_s6 <= c2_s5;
			c_s6  <= c_s5;
		end
		if (en_s[7] && v_s[6]) begin
			prod_s7 <= t_s6 * $signed({1'b0, c2_s6});
			c_s7    <= c_s6;
		end
		if (en_s[8] && v_s[7]) begin
			t_s8 <= horner(fad_pkg::P1, prod_s7);
			c_s8 <= c_s7;
		end
		if (en_s[9] && v_s[8]) begin
			prod_s9 <= t_s8 * $signed({1'b0, c_s8});
		end
		// A slightly negative result near zero is clamped to zero.
		if (en_s[10] && v_s[9]) begin
			a_s10 <= a_rnd[RND_W-1] ? '0 : a_rnd[AW-1:0];
		end
	end

	assign out_valid = v_s[NSTG];
	assign raw_ang   = a_s10;
	assign side_out  = side_s[NSTG];

endmodule

[design/fad_fold.sv]
// Rounds the octant angle to the output scale and unfolds it to 0..360 degrees.
// Two pipeline stages, the second is the output register; depends on fad_pkg.
module fad_fold #(
	parameter int ANGLE_FRAC_BITS = fad_pkg::ANGLE_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fad_pkg::RAW_ANG_W-1:0]   raw_ang,
	input  fad_pkg::side_t                  side_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fad_pkg::OUT_W-1:0]       angle_deg
);

	localparam int AW    = fad_pkg::RAW_ANG_W;
	localparam int SH    = fad_pkg::COEF_FRAC - ANGLE_FRAC_BITS;
	localparam int ANG_W = ANGLE_FRAC_BITS + 9;
	localparam int RES_W = (ANG_W > fad_pkg::OUT_W) ? ANG_W : fad_pkg::OUT_W;

	localparam logic [AW:0]      HALF   = (AW + 1)'(1) << (SH - 1);
	localparam logic [RES_W-1:0] DEG90  = RES_W'(90) << ANGLE_FRAC_BITS;
	localparam logic [RES_W-1:0] DEG180 = RES_W'(180) << ANGLE_FRAC_BITS;
	localparam logic [RES_W-1:0] DEG360 = RES_W'(360) << ANGLE_FRAC_BITS;

	logic             v_s1, v_s2;
	logic             en_s1, en_s2;
	logic [RES_W-1:0] oct_s1;
	fad_pkg::side_t   side_s1;
	logic [RES_W-1:0] res_s2;

	logic [AW:0]      oct_sum;
	logic [RES_W-1:0] base;
	logic             flip;
	logic [RES_W-1:0] res;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign oct_sum = {1'b0, raw_ang} + HALF;

	// The three reflections fold into one offset and one sign on the octant angle.
	always_comb begin
		base = '0;
		flip = 1'b0;
		if (side_s1.swap) begin
			base = DEG90;
			flip = 1'b1;
		end
		if (side_s1.neg_x) begin
			base = DEG180 - base;
			flip = !flip;
		end
		if (side_s1.neg_y) begin
			base = DEG360 - base;
			flip = !flip;
		end
		res = flip ? (base - oct_s1) : (base + oct_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			oct_s1  <= RES_W'(oct_sum >> SH);
			side_s1 <= side_in;
		end
		if (en_s2 && v_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = v_s2;
	assign angle_deg = res_s2[fad_pkg::OUT_W-1:0];

endmodule

[design/fast_atan2_degrees_top.sv]
// Top level of the fast atan2 pipeline: direction of a gradient pair in degrees.
// Depends on fad_pkg, fad_in_if, fad_out_if, fad_front, fad_div, fad_poly, fad_fold.
//
// Usage:
//   The grad channel takes one signed pair (grad_y, grad_x) per transfer. The
//   angle channel returns one unsigned angle per transfer, 0 to 360 degrees in
//   units of 2^-ANGLE_FRAC_BITS degree, counterclockwise from the positive x
//   axis. Both inputs zero give an angle of zero; a full 360 degrees can appear
//   and is not wrapped. Results leave in the order the pairs arrived.
//   Pipeline: 32 register stages in all, in order from the input transfer:
//   2 front-end stages (magnitudes, octant select), 18 divider stages
//   (numerator plus one quotient bit per stage), 10 polynomial stages (one multiply
//   or one rounding add per stage) and 2 output stages (rounding, reflection).
//   Throughput is one pair per clock while angle.ready is high. Every stage
//   has its own valid bit and takes a new item whenever it is empty or its
//   successor moves on, so bubbles are squeezed out and input keeps flowing
//   while a result waits. When the receiver holds ready low the pipeline
//   fills up behind the output register and grad.ready falls once every stage
//   is occupied; nothing is lost or repeated. The asynchronous reset clears all
//   valid bits, so the block comes out of reset empty and ready to accept.
module fast_atan2_degrees_top #(
	parameter int IN_BITS         = fad_pkg::IN_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = fad_pkg::ANGLE_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fad_in_if.sink      grad,
	fad_out_if.source   angle
);

	logic                                 fr_valid, fr_ready;
	logic [IN_BITS-1:0]                   fr_lo, fr_hi;
	fad_pkg::side_t                       fr_side;

	logic                                 dv_valid, dv_ready;
	logic [fad_pkg::RATIO_W-1:0]          dv_ratio;
	fad_pkg::side_t                       dv_side;

	logic                                 pl_valid, pl_ready;
	logic [fad_pkg::RAW_ANG_W-1:0]        pl_ang;
	fad_pkg::side_t                       pl_side;

	fad_front #(
		.IN_BITS(IN_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (grad.valid),
		.in_ready (grad.ready),
		.grad_y   (grad.grad_y),
		.grad_x   (grad.grad_x),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.lo       (fr_lo),
		.hi       (fr_hi),
		.side     (fr_side)
	);

	// The ratio of the smaller magnitude to the larger one.
	fad_div #(
		.IN_BITS(IN_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.lo       (fr_lo),
		.hi       (fr_hi),
		.side_in  (fr_side),
		.out_valid(dv_valid),
		.out_ready(dv_ready),
		.ratio    (dv_ratio),
		.side_out (dv_side)
	);

	// Arctangent of the ratio within the first octant.
	fad_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.in_ready (dv_ready),
		.ratio    (dv_ratio),
		.side_in  (dv_side),
		.out_valid(pl_valid),
		.out_ready(pl_ready),
		.raw_ang  (pl_ang),
		.side_out (pl_side)
	);

	// Output scaling and quadrant reflection; its last stage drives the port.
	fad_fold #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pl_valid),
		.in_ready (pl_ready),
		.raw_ang  (pl_ang),
		.side_in  (pl_side),
		.out_valid(angle.valid),
		.out_ready(angle.ready),
		.angle_deg(angle.angle_deg)
	);

endmodule
